// ===== hdl/line_follow_pid_with_pivot_search_core_defines.svh =====
// assertion macros shared by the line follower core modules
// no dependencies; take in by include after the package import
`ifndef LINE_FOLLOW_PID_WITH_PIVOT_SEARCH_CORE_DEFINES_SVH
`define LINE_FOLLOW_PID_WITH_PIVOT_SEARCH_CORE_DEFINES_SVH

// condition and consequence in the same cycle
`define LFP_ASSERT_SAME(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define LFP_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lfp_pkg.sv =====
// types and constants of the line follower pid core
// no dependencies
`timescale 1ns / 1ps

package lfp_pkg;

	localparam int unsigned PWM_PERIOD  = 1000;
	localparam int unsigned PWM_STEP    = PWM_PERIOD / 100;
	localparam int          DRIVE_LIMIT = 100;
	localparam int          CMP_W       = 10;
	localparam int          CFG_IDX_W   = 3;
	localparam int          CFG_DATA_W  = 16;

	// mode codes
	localparam logic [1:0] MODE_FOLLOW = 2'd0;
	localparam logic [1:0] MODE_LOST   = 2'd1;
	localparam logic [1:0] MODE_PIVOT  = 2'd2;
	localparam logic [1:0] MODE_EXIT   = 2'd3;

	// bridge direction codes
	localparam logic [1:0] DIR_OFF  = 2'd0;
	localparam logic [1:0] DIR_PIN1 = 2'd1;
	localparam logic [1:0] DIR_PIN2 = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PIVOT_DRIVE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT_FRAMES = 3'd5;

	// register reset values
	localparam logic [7:0] CENTER_RESET      = 8'd80;
	localparam logic [6:0] PIVOT_DRIVE_RESET = 7'd10;
	localparam logic [3:0] EXIT_FRAMES_RESET = 4'd3;

	typedef struct packed {
		logic [7:0]        line_position;
		logic signed [7:0] base_drive;
		logic [3:0]        hit_count;
	} lfp_in_t;

	typedef struct packed {
		logic [CMP_W-1:0] left_compare;
		logic [1:0]       left_direction;
		logic [CMP_W-1:0] right_compare;
		logic [1:0]       right_direction;
		logic [1:0]       mode_code;
	} lfp_out_t;

	typedef struct packed {
		logic signed [15:0] gain_p;
		logic signed [15:0] gain_i;
		logic signed [15:0] gain_d;
		logic [7:0]         center_position;
		logic [6:0]         pivot_drive;
		logic [3:0]         exit_stop_frames;
	} lfp_cfg_t;

	// per-frame control carried down the pipeline
	typedef struct packed {
		logic              pid;
		logic [1:0]        mode;
		logic signed [7:0] left_cmd;
		logic signed [7:0] right_cmd;
		logic signed [7:0] base;
	} lfp_ctrl_t;

	typedef struct packed {
		logic [CMP_W-1:0] compare;
		logic [1:0]       direction;
	} lfp_wheel_t;

endpackage

// ===== hdl/line_follow_pid_with_pivot_search_core.sv =====
// Line follower control core: one frame in (line position, base drive, hit
// count), one result out (two wheel compare values and bridge codes, mode).
// A frame is accepted every clock while in_stall is low. The frame passes the
// decision/state stage, the gain multiplier stage and the result register,
// each registered, and its result can transfer from the result register. The
// search and pid state update when a frame is accepted, so frames may follow
// each other in consecutive cycles. in_stall is high only while the result
// register holds an untaken result and out_stall is high.
// Configuration writes are always ready and take effect the next cycle;
// write them only while no frame is in flight.
// depends on lfp_pkg and the lfp_* modules
`timescale 1ns / 1ps

module line_follow_pid_with_pivot_search_core import lfp_pkg::*; #(
	parameter int SUM_WIDTH = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  lfp_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output lfp_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lfp_cfg_t                     cfg;
	logic                         adv;
	logic                         s1_valid, s2_valid;
	lfp_ctrl_t                    s1_ctrl, s2_ctrl;
	logic signed [8:0]            s1_err;
	logic signed [9:0]            s1_diff;
	logic signed [SUM_WIDTH-1:0]  s1_sum;
	logic signed [24:0]           s2_prod_p;
	logic signed [SUM_WIDTH+15:0] s2_prod_i;
	logic signed [25:0]           s2_prod_d;

	// whole pipeline moves unless a finished result is held
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	lfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lfp_frame_ctrl #(.SUM_WIDTH(SUM_WIDTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.in_data  (in_data),
		.cfg      (cfg),
		.s1_valid (s1_valid),
		.s1_ctrl  (s1_ctrl),
		.s1_err   (s1_err),
		.s1_diff  (s1_diff),
		.s1_sum   (s1_sum)
	);

	lfp_pid_mult #(.SUM_WIDTH(SUM_WIDTH)) u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.cfg       (cfg),
		.s1_valid  (s1_valid),
		.s1_ctrl   (s1_ctrl),
		.s1_err    (s1_err),
		.s1_diff   (s1_diff),
		.s1_sum    (s1_sum),
		.s2_valid  (s2_valid),
		.s2_ctrl   (s2_ctrl),
		.s2_prod_p (s2_prod_p),
		.s2_prod_i (s2_prod_i),
		.s2_prod_d (s2_prod_d)
	);

	lfp_wheel_out #(.SUM_WIDTH(SUM_WIDTH)) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.s2_valid  (s2_valid),
		.s2_ctrl   (s2_ctrl),
		.s2_prod_p (s2_prod_p),
		.s2_prod_i (s2_prod_i),
		.s2_prod_d (s2_prod_d),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// ===== hdl/lfp_cfg_regs.sv =====
// configuration register file of the line follower core
// depends on lfp_pkg
`timescale 1ns / 1ps

module lfp_cfg_regs import lfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output lfp_cfg_t              cfg
);

	lfp_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p           <= '0;
			cfg_q.gain_i           <= '0;
			cfg_q.gain_d           <= '0;
			cfg_q.center_position  <= CENTER_RESET;
			cfg_q.pivot_drive      <= PIVOT_DRIVE_RESET;
			cfg_q.exit_stop_frames <= EXIT_FRAMES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_P:      cfg_q.gain_p           <= $signed(cfg_data);
				REG_GAIN_I:      cfg_q.gain_i           <= $signed(cfg_data);
				REG_GAIN_D:      cfg_q.gain_d           <= $signed(cfg_data);
				REG_CENTER:      cfg_q.center_position  <= cfg_data[7:0];
				REG_PIVOT_DRIVE: cfg_q.pivot_drive      <= cfg_data[6:0];
				REG_EXIT_FRAMES: cfg_q.exit_stop_frames <= cfg_data[3:0];
				default: begin
					// unmapped index, write dropped
				end
			endcase
		end
	end

endmodule

// ===== hdl/lfp_frame_ctrl.sv =====
// frame decision, search state and pid error state; first pipeline stage
// depends on lfp_pkg and the core defines header
`timescale 1ns / 1ps

module lfp_frame_ctrl import lfp_pkg::*; #(
	parameter int SUM_WIDTH = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_valid,
	input  lfp_in_t                     in_data,
	input  lfp_cfg_t                    cfg,
	output logic                        s1_valid,
	output lfp_ctrl_t                   s1_ctrl,
	output logic signed [8:0]           s1_err,
	output logic signed [9:0]           s1_diff,
	output logic signed [SUM_WIDTH-1:0] s1_sum
);

`include "line_follow_pid_with_pivot_search_core_defines.svh"

	localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

	logic                        pivot_active_q, pivot_hold_q, pivot_left_q;
	logic [3:0]                  exit_cd_q;
	logic signed [SUM_WIDTH-1:0] error_sum_q;
	logic signed [8:0]           prev_err_q;

	logic                        pivot_active_d, pivot_hold_d, pivot_left_d;
	logic [3:0]                  exit_cd_d;
	logic signed [SUM_WIDTH-1:0] error_sum_d;
	logic signed [8:0]           prev_err_d;

	logic                        accept;
	logic signed [8:0]           err;
	logic signed [9:0]           diff;
	logic signed [SUM_WIDTH:0]   sum_ext;
	logic signed [SUM_WIDTH-1:0] sum_sat;
	logic signed [7:0]           drive_pos, drive_neg;
	lfp_ctrl_t                   ctrl;

	assign accept = in_valid && adv;

	assign err  = $signed({1'b0, in_data.line_position}) - $signed({1'b0, cfg.center_position});
	assign diff = $signed({err[8], err}) - $signed({prev_err_q[8], prev_err_q});

	// running sum with clamp at the signed range
	assign sum_ext = $signed({error_sum_q[SUM_WIDTH-1], error_sum_q})
		+ $signed({{(SUM_WIDTH-8){err[8]}}, err});
	always_comb begin
		if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
			sum_sat = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_sat = sum_ext[SUM_WIDTH-1:0];
		end
	end

	assign drive_pos = $signed({1'b0, cfg.pivot_drive});
	assign drive_neg = -drive_pos;

	always_comb begin
		pivot_active_d = pivot_active_q;
		pivot_hold_d   = pivot_hold_q;
		pivot_left_d   = pivot_left_q;
		exit_cd_d      = exit_cd_q;
		error_sum_d    = error_sum_q;
		prev_err_d     = prev_err_q;
		ctrl.pid       = 1'b0;
		ctrl.mode      = MODE_FOLLOW;
		ctrl.left_cmd  = '0;
		ctrl.right_cmd = '0;
		ctrl.base      = in_data.base_drive;
		if (exit_cd_q != 4'd0) begin
			exit_cd_d = exit_cd_q - 4'd1;
			ctrl.mode = MODE_EXIT;
			if (exit_cd_q == 4'd1) begin
				pivot_active_d = 1'b0;
				pivot_left_d   = 1'b0;
				error_sum_d    = '0;
				prev_err_d     = '0;
			end
		end else if (pivot_active_q && in_data.hit_count >= 4'd2) begin
			exit_cd_d = (cfg.exit_stop_frames == 4'd0) ? 4'd1 : cfg.exit_stop_frames;
			ctrl.mode = MODE_EXIT;
		end else if (pivot_active_q) begin
			ctrl.mode = MODE_PIVOT;
			if (pivot_hold_q) begin
				pivot_hold_d = 1'b0;
			end else if (pivot_left_q) begin
				ctrl.left_cmd  = drive_neg;
				ctrl.right_cmd = drive_pos;
			end else begin
				ctrl.left_cmd  = drive_pos;
				ctrl.right_cmd = drive_neg;
			end
		end else if (in_data.hit_count == 4'd0) begin
			pivot_active_d = 1'b1;
			pivot_hold_d   = 1'b1;
			pivot_left_d   = in_data.line_position < cfg.center_position;
			ctrl.mode      = MODE_LOST;
		end else begin
			ctrl.pid    = 1'b1;
			error_sum_d = sum_sat;
			prev_err_d  = err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pivot_active_q <= 1'b0;
			pivot_hold_q   <= 1'b0;
			pivot_left_q   <= 1'b0;
			exit_cd_q      <= '0;
			error_sum_q    <= '0;
			prev_err_q     <= '0;
			s1_valid       <= 1'b0;
		end else begin
			if (accept) begin
				pivot_active_q <= pivot_active_d;
				pivot_hold_q   <= pivot_hold_d;
				pivot_left_q   <= pivot_left_d;
				exit_cd_q      <= exit_cd_d;
				error_sum_q    <= error_sum_d;
				prev_err_q     <= prev_err_d;
			end
			if (adv) begin
				s1_valid <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_ctrl <= ctrl;
			s1_err  <= err;
			s1_diff <= diff;
			s1_sum  <= sum_sat;
		end
	end

	`LFP_ASSERT_SAME(a_countdown_in_search, clk, arst_n, exit_cd_q != 4'd0, pivot_active_q, "exit countdown running outside a search")
	`LFP_ASSERT_NEXT(a_countdown_steps, clk, arst_n, accept && exit_cd_q != 4'd0, exit_cd_q == $past(exit_cd_q) - 4'd1, "exit countdown did not step down by one")
	`LFP_ASSERT_NEXT(a_pid_frame_keeps_search, clk, arst_n, accept && ctrl.pid, !pivot_active_q && exit_cd_q == 4'd0, "pid frame changed search state")

endmodule

// ===== hdl/lfp_pid_mult.sv =====
// pid gain products; second pipeline stage
// depends on lfp_pkg
`timescale 1ns / 1ps

module lfp_pid_mult import lfp_pkg::*; #(
	parameter int SUM_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  lfp_cfg_t                       cfg,
	input  logic                           s1_valid,
	input  lfp_ctrl_t                      s1_ctrl,
	input  logic signed [8:0]              s1_err,
	input  logic signed [9:0]              s1_diff,
	input  logic signed [SUM_WIDTH-1:0]    s1_sum,
	output logic                           s2_valid,
	output lfp_ctrl_t                      s2_ctrl,
	output logic signed [24:0]             s2_prod_p,
	output logic signed [SUM_WIDTH+15:0]   s2_prod_i,
	output logic signed [25:0]             s2_prod_d
);

	logic signed [24:0]           prod_p;
	logic signed [SUM_WIDTH+15:0] prod_i;
	logic signed [25:0]           prod_d;

	assign prod_p = 25'(cfg.gain_p) * 25'(s1_err);
	assign prod_i = (SUM_WIDTH+16)'(cfg.gain_i) * (SUM_WIDTH+16)'(s1_sum);
	assign prod_d = 26'(cfg.gain_d) * 26'(s1_diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (adv) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_ctrl   <= s1_ctrl;
			s2_prod_p <= prod_p;
			s2_prod_i <= prod_i;
			s2_prod_d <= prod_d;
		end
	end

endmodule

// ===== hdl/lfp_wheel_out.sv =====
// pid sum, wheel commands, bridge codes and the result register
// depends on lfp_pkg and the core defines header
`timescale 1ns / 1ps

module lfp_wheel_out import lfp_pkg::*; #(
	parameter int SUM_WIDTH = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic                         s2_valid,
	input  lfp_ctrl_t                    s2_ctrl,
	input  logic signed [24:0]           s2_prod_p,
	input  logic signed [SUM_WIDTH+15:0] s2_prod_i,
	input  logic signed [25:0]           s2_prod_d,
	output logic                         out_valid,
	output lfp_out_t                     out_data
);

`include "line_follow_pid_with_pivot_search_core_defines.svh"

	localparam int TW = SUM_WIDTH + 19;
	localparam logic signed [TW-1:0] LIM_HI = TW'(DRIVE_LIMIT);
	localparam logic signed [TW-1:0] LIM_LO = -TW'(DRIVE_LIMIT);

	logic signed [TW-1:0] acc, base_q8, left_raw, right_raw;
	logic signed [7:0]    left_pid, right_pid, left_cmd, right_cmd;
	lfp_wheel_t           left_w, right_w;
	lfp_out_t             res;

	// divide by 256 rounding toward zero, then clamp to the drive limit
	function automatic logic signed [7:0] scale_sat(input logic signed [TW-1:0] x);
		logic signed [TW-1:0] q;
		q = x >>> 8;
		if (x[TW-1] && (x[7:0] != 8'd0)) begin
			q = q + TW'(1);
		end
		if (q > LIM_HI) begin
			q = LIM_HI;
		end else if (q < LIM_LO) begin
			q = LIM_LO;
		end
		return q[7:0];
	endfunction

	// bridge runs inverted; compare is period minus period*|v|/100
	function automatic lfp_wheel_t drive_wheel(input logic signed [7:0] cmd);
		logic signed [8:0] v;
		logic [6:0]        mag;
		logic [16:0]       cmp;
		lfp_wheel_t        w;
		v = -{cmd[7], cmd};
		if (v > 9'sd100) begin
			v = 9'sd100;
		end else if (v < -9'sd100) begin
			v = -9'sd100;
		end
		mag = v[8] ? 7'(-v) : v[6:0];
		cmp = 17'(PWM_PERIOD) - 17'(PWM_STEP) * 17'(mag);
		w.compare = cmp[CMP_W-1:0];
		if (v > 9'sd0) begin
			w.direction = DIR_PIN1;
		end else if (v < 9'sd0) begin
			w.direction = DIR_PIN2;
		end else begin
			w.direction = DIR_OFF;
		end
		return w;
	endfunction

	assign acc = TW'(s2_prod_p) + TW'(s2_prod_i) + TW'(s2_prod_d);
	assign base_q8 = TW'(s2_ctrl.base) <<< 8;
	assign left_raw  = base_q8 + acc;
	assign right_raw = base_q8 - acc;

	assign left_pid  = scale_sat(left_raw);
	assign right_pid = scale_sat(right_raw);
	assign left_cmd  = s2_ctrl.pid ? left_pid : s2_ctrl.left_cmd;
	assign right_cmd = s2_ctrl.pid ? right_pid : s2_ctrl.right_cmd;

	assign left_w  = drive_wheel(left_cmd);
	assign right_w = drive_wheel(right_cmd);

	always_comb begin
		res.left_compare    = left_w.compare;
		res.left_direction  = left_w.direction;
		res.right_compare   = right_w.compare;
		res.right_direction = right_w.direction;
		res.mode_code       = s2_ctrl.mode;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= res;
		end
	end

	`LFP_ASSERT_SAME(a_stop_frame_idle, clk, arst_n, out_valid && (out_data.mode_code == MODE_LOST || out_data.mode_code == MODE_EXIT), out_data.left_compare == CMP_W'(PWM_PERIOD) && out_data.right_compare == CMP_W'(PWM_PERIOD) && out_data.left_direction == DIR_OFF && out_data.right_direction == DIR_OFF, "stop frame drives a wheel")
	`LFP_ASSERT_SAME(a_dir_code_legal, clk, arst_n, out_valid, out_data.left_direction != 2'd3 && out_data.right_direction != 2'd3, "both bridge pins high")

endmodule
